@@ hdl/ifd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and codes of the IPv4 forwarding decision unit.
// ----------------------------------------------------------------------------
package ifd_pkg;

  typedef enum logic [1:0] {
    ACT_ROUTE    = 2'd0,
    ACT_NEIGHBOR = 2'd1,
    ACT_PORT     = 2'd2,
    ACT_FORWARD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    VERDICT_FORWARD     = 3'd0,
    VERDICT_DROP        = 3'd1,
    VERDICT_ECHO_REPLY  = 3'd2,
    VERDICT_UNREACHABLE = 3'd3,
    VERDICT_TIME_EXCEED = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUTE = 2'd1,
    ST_NEIGH = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  localparam logic [7:0] PROTO_ICMP      = 8'h01;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP_UNREACH    = 8'd3;
  localparam logic [7:0] ICMP_TIME_EXC   = 8'd11;

  // Running best route match kept during the route scan.
  typedef struct packed {
    logic        found;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [1:0]  port;
  } route_best_t;

  typedef struct packed {
    logic        found;
    logic [47:0] mac;
  } neigh_best_t;

endpackage

@@ hdl/ifd_ram.sv @@
// ----------------------------------------------------------------------------
// ifd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ifd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/ifd_neigh_cell.sv @@
// ----------------------------------------------------------------------------
// ifd_neigh_cell
// One neighbor table entry; shifts the probed gateway and best match along.
// ----------------------------------------------------------------------------
module ifd_neigh_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [31:0]          wr_ip,
  input  logic [47:0]          wr_mac,
  input  logic [31:0]          gw_in,
  input  ifd_pkg::neigh_best_t best_in,
  output logic [31:0]          gw_out,
  output ifd_pkg::neigh_best_t best_out
);
  import ifd_pkg::*;

  logic        valid_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  neigh_best_t best_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_r  <= wr_ip;
      mac_r <= wr_mac;
    end
    gw_out   <= gw_in;
    best_out <= best_nxt;
  end

  // Earlier cells hold lower slots; keep their hit.
  always_comb begin
    best_nxt = best_in;
    if (!best_in.found && valid_r && ip_r == gw_in) begin
      best_nxt.found = 1'b1;
      best_nxt.mac   = mac_r;
    end
  end

endmodule

@@ hdl/ipv4_forwarding_decision_unit.sv @@
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_unit
// Slow-path IPv4 forwarding decision with longest-prefix route match.
// ----------------------------------------------------------------------------
// After reset the unit clears the route RAM one slot per cycle, holding
// in_tready low until the clearing pass is done. Write transactions
// (route, neighbor, port address) are taken one per cycle while the unit is
// idle. A forward transaction scans the route RAM one slot per cycle through
// the read register, then sends the chosen gateway through a chain of
// NEIGHBOR_DEPTH neighbor cells, one cell per cycle, and delivers one
// result. Unreachable and time exceeded are known after the scan. A bad
// checksum or an echo request to the ingress port's own address is answered
// without a scan. One transaction is in work at a time; the result sits in
// an output register until taken, and in_tready returns once the state
// machine has gone from its output state back to idle. Each route RAM word
// carries its own valid bit; a route write with a zero mask clears the slot.
// Neighbor writes use the slot modulo NEIGHBOR_DEPTH. Among matching routes
// the largest mask wins, ties to the lowest slot; among neighbors the lowest
// matching slot wins.
module ipv4_forwarding_decision_unit #(
  parameter int ROUTE_DEPTH    = 1024,
  parameter int NEIGHBOR_DEPTH = 16,
  parameter int PORT_COUNT     = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], entry_slot[11:2], address[43:12], net_mask[75:44],
  // gateway[107:76], port[109:108], mac_address[157:110], ttl[165:158],
  // protocol[173:166], icmp_type[181:174], header_checksum[197:182],
  // checksum_good[198], zero fill [199]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // verdict[2:0], out_port[4:3], next_hop_mac[52:5], new_ttl[60:53],
  // new_checksum[76:61], reply_icmp_type[84:77], zero fill [87:85]
  output logic [87:0]  out_tdata
);
  import ifd_pkg::*;

  localparam int RAW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int NAW = (NEIGHBOR_DEPTH > 1) ? $clog2(NEIGHBOR_DEPTH) : 1;
  localparam int PAW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int RCW = $clog2(ROUTE_DEPTH + 2);
  localparam int NCW = $clog2(NEIGHBOR_DEPTH + 1);
  localparam int RW  = 99; // prefix, mask, gateway, port, valid
  // Reciprocal of NEIGHBOR_DEPTH, exact for every 10-bit slot.
  localparam int NSH    = 20;
  localparam int NRECIP = ((1 << NSH) + NEIGHBOR_DEPTH - 1) / NEIGHBOR_DEPTH;

  // Unpack input fields.
  logic [1:0]  f_action;
  logic [9:0]  f_slot;
  logic [31:0] f_addr, f_mask, f_gw;
  logic [1:0]  f_port;
  logic [47:0] f_mac;
  logic [7:0]  f_ttl, f_proto, f_itype;
  logic [15:0] f_hc;
  logic        f_good;
  assign f_action = in_tdata[1:0];
  assign f_slot   = in_tdata[11:2];
  assign f_addr   = in_tdata[43:12];
  assign f_mask   = in_tdata[75:44];
  assign f_gw     = in_tdata[107:76];
  assign f_port   = in_tdata[109:108];
  assign f_mac    = in_tdata[157:110];
  assign f_ttl    = in_tdata[165:158];
  assign f_proto  = in_tdata[173:166];
  assign f_itype  = in_tdata[181:174];
  assign f_hc     = in_tdata[197:182];
  assign f_good   = in_tdata[198];

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  // Captured transaction.
  state_t      state_r, state_nxt;
  logic [31:0] dst_r;
  logic [1:0]  port_r;
  logic [7:0]  ttl_r, proto_r;
  logic [15:0] hc_r;
  logic        quick_r;      // answered without a scan
  logic [2:0]  quick_verdict_r;

  // Route scan.
  logic [RCW-1:0] rcnt_r;
  logic [RAW-1:0] raddr;
  logic [RW-1:0]  rdata;
  logic [RW-1:0]  r_wdata;
  logic           r_we;
  logic           rd_vld_r;
  route_best_t    rbest_r;

  // Clearing pass after reset.
  logic           clr_busy_r;
  logic [RAW-1:0] clr_cnt_r;

  // Port addresses.
  logic [31:0] port_ip_r [PORT_COUNT];
  logic [PAW-1:0] pidx;
  assign pidx = PAW'(f_port);

  // Result register.
  logic        out_vld_r;
  logic [87:0] out_data_r;

  logic slot_ok, port_ok;
  assign slot_ok = ({22'd0, f_slot} < 32'(ROUTE_DEPTH));
  assign port_ok = ({30'd0, f_port} < 32'(PORT_COUNT));

  assign r_we    = clr_busy_r || (in_fire && f_action == ACT_ROUTE && slot_ok);
  assign raddr   = clr_busy_r ? clr_cnt_r :
                   (in_fire ? RAW'(f_slot) : rcnt_r[RAW-1:0]);
  assign r_wdata = clr_busy_r ? '0 : {f_mask != 32'd0, f_port, f_gw, f_mask, f_addr};

  ifd_ram #(.WIDTH(RW), .DEPTH(ROUTE_DEPTH)) u_route_ram (
    .clk   (clk),
    .we    (r_we),
    .addr  (raddr),
    .wdata (r_wdata),
    .rdata (rdata)
  );

  // Neighbor chain.
  logic [31:0]  gw_chain   [NEIGHBOR_DEPTH+1];
  neigh_best_t  best_chain [NEIGHBOR_DEPTH+1];
  logic [NAW-1:0] nslot;
  logic [NCW-1:0] ncnt_r;
  logic [30:0]    nprod;
  logic [9:0]     nquo;
  logic [19:0]    nbase;
  logic [9:0]     nrem;
  // Slot modulo NEIGHBOR_DEPTH by reciprocal multiplication.
  assign nprod = {21'd0, f_slot} * 31'(NRECIP);
  assign nquo  = nprod[NSH +: 10];
  assign nbase = 20'(nquo) * 20'(NEIGHBOR_DEPTH);
  assign nrem  = f_slot - nbase[9:0];
  assign nslot = NAW'(nrem);
  assign gw_chain[0]   = rbest_r.gateway;
  assign best_chain[0] = '0;

  for (genvar g = 0; g < NEIGHBOR_DEPTH; g++) begin : g_neigh
    ifd_neigh_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (in_fire && f_action == ACT_NEIGHBOR && nslot == NAW'(g)),
      .wr_ip    (f_addr),
      .wr_mac   (f_mac),
      .gw_in    (gw_chain[g]),
      .best_in  (best_chain[g]),
      .gw_out   (gw_chain[g+1]),
      .best_out (best_chain[g+1])
    );
  end

  // Route compare on registered read data.
  logic [31:0] e_prefix, e_mask, e_gw;
  logic [1:0]  e_port;
  logic        e_valid;
  logic        e_hit;
  assign {e_valid, e_port, e_gw, e_mask, e_prefix} = rdata;
  assign e_hit = rd_vld_r && e_valid &&
                 ((dst_r & e_mask) == (e_prefix & e_mask)) &&
                 (!rbest_r.found || e_mask > rbest_r.mask);

  logic scan_done, chain_done;
  assign scan_done  = (rcnt_r == RCW'(ROUTE_DEPTH + 1));
  assign chain_done = (ncnt_r == NCW'(NEIGHBOR_DEPTH));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && f_action == ACT_FORWARD) begin
          state_nxt = ST_ROUTE;
        end
      end
      ST_ROUTE: begin
        if (quick_r) begin
          state_nxt = ST_OUT;
        end else if (scan_done) begin
          state_nxt = (rbest_r.found && ttl_r > 8'd1) ? ST_NEIGH : ST_OUT;
        end
      end
      ST_NEIGH: begin
        if (chain_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result build.
  logic [7:0]  nttl;
  logic [16:0] s1;
  logic [15:0] s2, ncs;
  logic [87:0] result;
  neigh_best_t nb;
  assign nb   = best_chain[NEIGHBOR_DEPTH];
  assign nttl = ttl_r - 8'd1;
  always_comb begin
    s1  = {1'b0, ~hc_r} + {1'b0, ~{ttl_r, proto_r}};
    s1  = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    s1  = {1'b0, s1[15:0]} + {1'b0, nttl, proto_r};
    s2  = s1[15:0] + {15'd0, s1[16]};
    ncs = ~s2;
    result = '0;
    if (quick_r) begin
      result[2:0] = quick_verdict_r;
      if (quick_verdict_r == VERDICT_ECHO_REPLY) begin
        result[4:3]   = port_r;
        result[84:77] = ICMP_ECHO_REPLY;
      end
    end else if (!rbest_r.found) begin
      result[2:0]   = VERDICT_UNREACHABLE;
      result[4:3]   = port_r;
      result[84:77] = ICMP_UNREACH;
    end else if (ttl_r <= 8'd1) begin
      result[2:0]   = VERDICT_TIME_EXCEED;
      result[4:3]   = port_r;
      result[84:77] = ICMP_TIME_EXC;
    end else if (!nb.found) begin
      result[2:0] = VERDICT_DROP;
    end else begin
      result[2:0]   = VERDICT_FORWARD;
      result[4:3]   = rbest_r.port;
      result[52:5]  = nb.mac;
      result[60:53] = nttl;
      result[76:61] = ncs;
    end
  end

  logic emit;
  assign emit = (state_r == ST_ROUTE && (quick_r || (scan_done &&
                 !(rbest_r.found && ttl_r > 8'd1)))) ||
                (state_r == ST_NEIGH && chain_done);

  // Outputs.
  always_comb begin
    in_tready  = (state_r == ST_IDLE) && !clr_busy_r;
    out_tvalid = out_vld_r;
    out_tdata  = out_data_r;
  end

  logic echo_hit;
  assign echo_hit = port_ok && f_addr == port_ip_r[pidx] &&
                    f_proto == PROTO_ICMP && f_itype == ICMP_ECHO_REQ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_vld_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      for (int p = 0; p < PORT_COUNT; p++) begin
        port_ip_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + RAW'(1);
        if (clr_cnt_r == RAW'(ROUTE_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (in_fire && f_action == ACT_PORT && port_ok) begin
        port_ip_r[pidx] <= f_addr;
      end
      rd_vld_r <= (state_r == ST_ROUTE) && !quick_r &&
                  (rcnt_r < RCW'(ROUTE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
    if (in_fire) begin
      dst_r   <= f_addr;
      port_r  <= f_port;
      ttl_r   <= f_ttl;
      proto_r <= f_proto;
      hc_r    <= f_hc;
      quick_r <= !f_good || echo_hit;
      quick_verdict_r <= !f_good ? VERDICT_DROP : VERDICT_ECHO_REPLY;
      rcnt_r  <= '0;
      ncnt_r  <= '0;
      rbest_r <= '0;
    end else begin
      if (state_r == ST_ROUTE && !scan_done) begin
        rcnt_r <= rcnt_r + RCW'(1);
      end
      if (e_hit) begin
        rbest_r.found   <= 1'b1;
        rbest_r.mask    <= e_mask;
        rbest_r.gateway <= e_gw;
        rbest_r.port    <= e_port;
      end
      if (state_r == ST_NEIGH && !chain_done) begin
        ncnt_r <= ncnt_r + NCW'(1);
      end
    end
  end

endmodule

@@ hdl/ifd_checker.sv @@
// ----------------------------------------------------------------------------
// ifd_checker
// Port-level checks of the forwarding decision unit.
// ----------------------------------------------------------------------------
module ifd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("verdict code out of range");

  a_forward_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd0 |-> out_tdata[60:53] != 8'd0)
    else $error("forward with zero ttl");

endmodule

bind ipv4_forwarding_decision_unit ifd_checker u_ifd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/ipv4_forwarding_decision_checker.sv @@
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_checker
// Watches both streams of the forwarding unit, keeps a shadow copy of its
// tables, predicts each verdict and compares all its fields.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [199:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [87:0]  out_tdata,
  output int           fail_count,
  output int           verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ifd_pkg::*;

  localparam int ROUTES = 1024;
  localparam int NEIGHBORS = 16;
  localparam int PORTS = 4;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  port;
    logic [47:0] mac;
    logic [7:0]  ttl;
    logic [15:0] csum;
    logic [7:0]  icmp;
  } decision_t;

  logic [31:0] rt_prefix [ROUTES];
  logic [31:0] rt_mask   [ROUTES];
  logic [31:0] rt_gw     [ROUTES];
  logic [1:0]  rt_port   [ROUTES];
  logic        rt_valid  [ROUTES];
  logic [31:0] nb_ip     [NEIGHBORS];
  logic [47:0] nb_mac    [NEIGHBORS];
  logic        nb_valid  [NEIGHBORS];
  logic [31:0] local_ip  [PORTS];

  decision_t verdict_queue[$];

  assign verdicts_pending = verdict_queue.size();

  // Apply one input transaction to the shadow tables; queue a verdict for headers.
  function automatic void absorb_header(logic [199:0] d);
    action_t     act;
    logic [9:0]  slot;
    logic [31:0] addr, mask, gw, bmask;
    logic [1:0]  port;
    logic [47:0] mac;
    logic [7:0]  ttl, proto, itype;
    logic [15:0] hc, m_old, m_new;
    logic [17:0] sum;
    logic        good, found;
    int          best;
    decision_t   r;
    act = action_t'(d[1:0]);
    slot = d[11:2]; addr = d[43:12]; mask = d[75:44]; gw = d[107:76];
    port = d[109:108]; mac = d[157:110]; ttl = d[165:158];
    proto = d[173:166]; itype = d[181:174]; hc = d[197:182]; good = d[198];
    r = '0;
    case (act)
      ACT_ROUTE: begin
        if (mask == 0) begin
          rt_valid[slot] = 1'b0;
        end else begin
          rt_prefix[slot] = addr; rt_mask[slot] = mask;
          rt_gw[slot] = gw; rt_port[slot] = port; rt_valid[slot] = 1'b1;
        end
        return;
      end
      ACT_NEIGHBOR: begin
        nb_ip[slot[3:0]] = addr; nb_mac[slot[3:0]] = mac; nb_valid[slot[3:0]] = 1'b1;
        return;
      end
      ACT_PORT: begin
        local_ip[port] = addr;
        return;
      end
      default: ;
    endcase
    if (!good) begin
      r.verdict = VERDICT_DROP;
    end else if (addr == local_ip[port] && proto == PROTO_ICMP && itype == ICMP_ECHO_REQ) begin
      r.verdict = VERDICT_ECHO_REPLY; r.port = port; r.icmp = ICMP_ECHO_REPLY;
    end else begin
      found = 1'b0; best = 0; bmask = '0;
      for (int i = 0; i < ROUTES; i++)
        if (rt_valid[i] && (addr & rt_mask[i]) == (rt_prefix[i] & rt_mask[i]) &&
            (!found || rt_mask[i] > bmask)) begin
          found = 1'b1; best = i; bmask = rt_mask[i];
        end
      if (!found) begin
        r.verdict = VERDICT_UNREACHABLE; r.port = port; r.icmp = ICMP_UNREACH;
      end else if (ttl <= 1) begin
        r.verdict = VERDICT_TIME_EXCEED; r.port = port; r.icmp = ICMP_TIME_EXC;
      end else begin
        found = 1'b0;
        for (int i = 0; i < NEIGHBORS; i++)
          if (!found && nb_valid[i] && nb_ip[i] == rt_gw[best]) begin
            found = 1'b1; mac = nb_mac[i];
          end
        if (!found) begin
          r.verdict = VERDICT_DROP;
        end else begin
          // incremental checksum update over the TTL/protocol word
          m_old = {ttl, proto};
          m_new = {ttl - 8'd1, proto};
          sum = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
          sum = 18'(sum[15:0]) + 18'(sum[17:16]);
          sum = 18'(sum[15:0]) + 18'(sum[17:16]);
          r.verdict = VERDICT_FORWARD; r.port = rt_port[best]; r.mac = mac;
          r.ttl = ttl - 8'd1; r.csum = ~sum[15:0];
        end
      end
    end
    verdict_queue.push_back(r);
  endfunction

  always @(posedge clk) begin
    decision_t e, a;
    if (!rst_n) begin
      fail_count <= 0;
      verdict_queue.delete();
      for (int i = 0; i < ROUTES; i++) rt_valid[i] = 1'b0;
      for (int i = 0; i < NEIGHBORS; i++) nb_valid[i] = 1'b0;
      for (int i = 0; i < PORTS; i++) local_ip[i] = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        a = {out_tdata[2:0], out_tdata[4:3], out_tdata[52:5], out_tdata[60:53],
             out_tdata[76:61], out_tdata[84:77]};
        if (verdict_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected verdict transaction %h", a);
          fail_count <= fail_count + 1;
        end else begin
          e = verdict_queue.pop_front();
          if (a !== e) begin
            if (fail_count < 10)
              $display("verdict mismatch: expected v=%0d p=%0d mac=%h ttl=%h sum=%h icmp=%0d",
                       e.verdict, e.port, e.mac, e.ttl, e.csum, e.icmp,
                       ", got v=%0d p=%0d mac=%h ttl=%h sum=%h icmp=%0d",
                       a.verdict, a.port, a.mac, a.ttl, a.csum, a.icmp);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) absorb_header(in_tdata);
    end
  end
endmodule

@@ bench/ipv4_forwarding_decision_unit_test.sv @@
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_unit_test
// Drives table writes and IPv4 header digests into the forwarding unit with
// random gaps and back-pressure; the checker predicts every verdict.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ifd_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [199:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  int           fail_count;
  int           verdicts_pending;
  int           cycle_count = 0;
  bit           hold_output = 1'b0;

  // Small pools of addresses so that routes, neighbors and headers collide.
  logic [31:0] gw_pool [8];
  logic [31:0] net_pool [8];
  logic [31:0] local_pool [4];

  ipv4_forwarding_decision_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  ipv4_forwarding_decision_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .verdicts_pending(verdicts_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pack one transaction, lowest field first, and hold it until accepted.
  task automatic send_item(action_t act, logic [9:0] slot, logic [31:0] addr,
                           logic [31:0] mask, logic [31:0] gw, logic [1:0] port,
                           logic [47:0] mac, logic [7:0] ttl, logic [7:0] proto,
                           logic [7:0] itype, logic [15:0] hc, logic good);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {1'b0, good, hc, itype, proto, ttl, mac, port, gw, mask, addr, slot, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_header(logic [31:0] dst, logic [1:0] port, logic [7:0] ttl,
                             logic [7:0] proto, logic [7:0] itype, logic good);
    send_item(ACT_FORWARD, 10'($urandom), dst, $urandom, $urandom, port,
              {$urandom, $urandom}, ttl, proto, itype, 16'($urandom), good);
  endtask

  // Contiguous mask of the given prefix length, at least one bit.
  function automatic logic [31:0] prefix_mask(int len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic logic [31:0] pick_dst();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1, 2: return net_pool[$urandom_range(0, 7)] | ($urandom & 32'h0000_FFFF);
      3: return local_pool[$urandom_range(0, 3)];
      default: return net_pool[$urandom_range(0, 7)] | ($urandom & 32'h0000_00FF);
    endcase
  endfunction

  // Receiver: random stalls, stretches without stalls, and one long hold-off.
  always @(posedge clk) begin
    int wait_left;
    if (hold_output) begin
      out_tready <= 1'b0;
    end else if (wait_left > 0) begin
      wait_left--;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      wait_left = (cycle_count / 20000) % 3 == 0 ? 0 : $urandom_range(0, 17);
      out_tready <= (wait_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int kind, len, s;
    for (int i = 0; i < 8; i++) begin
      gw_pool[i] = $urandom;
      net_pool[i] = {8'(i + 10), 8'($urandom), 16'h0};
    end
    for (int i = 0; i < 4; i++) local_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unreachable before any route, bad checksum, echo to address zero.
    send_header(32'h0, 2'd0, 8'd64, PROTO_ICMP, ICMP_ECHO_REQ, 1'b1);
    send_header(32'hFFFF_FFFF, 2'd3, 8'd64, 8'd6, 8'd0, 1'b1);
    send_header(32'h0A00_0001, 2'd1, 8'd64, 8'd6, 8'd0, 1'b0);
    for (int p = 0; p < 4; p++)
      send_item(ACT_PORT, 10'd0, local_pool[p], '0, '0, 2'(p), '0, '0, '0, '0, '0, 1'b0);
    send_item(ACT_ROUTE, 10'd1023, 32'h0A00_0000, prefix_mask(8), gw_pool[0], 2'd3,
              '0, '0, '0, '0, '0, 1'b0);
    send_item(ACT_ROUTE, 10'd0, 32'h0A01_0000, prefix_mask(16), gw_pool[1], 2'd2,
              '0, '0, '0, '0, '0, 1'b0);
    send_item(ACT_ROUTE, 10'd5, 32'h0A01_0203, 32'hFFFF_FFFF, gw_pool[2], 2'd1,
              '0, '0, '0, '0, '0, 1'b0);
    send_item(ACT_NEIGHBOR, 10'd1023, gw_pool[0], '0, '0, '0, 48'hFFFF_FFFF_FFFF,
              '0, '0, '0, '0, 1'b0);
    send_item(ACT_NEIGHBOR, 10'd16, gw_pool[1], '0, '0, '0, 48'h0, '0, '0, '0, '0, 1'b0);
    send_header(32'h0A01_0203, 2'd0, 8'd255, 8'hFF, 8'hFF, 1'b1); // host route, no neighbor
    send_header(32'h0A01_7777, 2'd0, 8'd2, 8'd6, 8'd0, 1'b1);     // forward, ttl 2
    send_header(32'h0AFF_0000, 2'd1, 8'd1, 8'd17, 8'd0, 1'b1);    // time exceeded
    send_header(32'h0A02_0000, 2'd2, 8'd0, 8'd17, 8'd0, 1'b1);
    send_header(local_pool[2], 2'd2, 8'd9, PROTO_ICMP, 8'd0, 1'b1); // local, not echo
    send_header(local_pool[1], 2'd2, 8'd9, PROTO_ICMP, ICMP_ECHO_REQ, 1'b1); // wrong port
    send_header(local_pool[3], 2'd3, 8'd9, PROTO_ICMP, ICMP_ECHO_REQ, 1'b1);
    send_item(ACT_ROUTE, 10'd5, 32'h0, 32'h0, '0, '0, '0, '0, '0, '0, '0, 1'b0); // clear
    send_header(32'h0A01_0203, 2'd1, 8'd128, 8'd6, 8'd0, 1'b1);

    // Random part; the long output hold-off comes early.
    for (int n = 0; n < 550; n++) begin
      if (n == 60) begin
        hold_output <= 1'b1;
        fork
          begin
            repeat (30000) @(posedge clk);
            hold_output <= 1'b0;
          end
        join_none
      end
      kind = $urandom_range(0, 99);
      s = $urandom_range(0, 7);
      if (kind < 12) begin
        len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 32) : $urandom_range(8, 24);
        send_item(ACT_ROUTE, 10'($urandom_range(0, 1023)),
                  net_pool[s] | ($urandom & 32'h00FF_FFFF),
                  $urandom_range(0, 9) == 0 ? 32'h0 : prefix_mask(len),
                  gw_pool[$urandom_range(0, 7)], 2'($urandom), '0, '0, '0, '0, '0,
                  1'($urandom));
      end else if (kind < 20) begin
        send_item(ACT_NEIGHBOR, 10'($urandom),
                  $urandom_range(0, 7) == 0 ? $urandom : gw_pool[s], $urandom, $urandom,
                  2'($urandom), {$urandom, $urandom}, 8'($urandom), 8'($urandom),
                  8'($urandom), 16'($urandom), 1'($urandom));
      end else if (kind < 23) begin
        s = $urandom_range(0, 3);
        local_pool[s] = $urandom_range(0, 1) ? $urandom : net_pool[s] | 32'h1;
        send_item(ACT_PORT, 10'($urandom), local_pool[s], $urandom, $urandom, 2'(s),
                  {$urandom, $urandom}, 8'($urandom), 8'($urandom), 8'($urandom),
                  16'($urandom), 1'($urandom));
      end else begin
        send_header(pick_dst(), 2'($urandom),
                    $urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 2)) : 8'($urandom),
                    $urandom_range(0, 1) ? PROTO_ICMP : 8'($urandom),
                    $urandom_range(0, 1) ? ICMP_ECHO_REQ : 8'($urandom),
                    $urandom_range(0, 9) != 0);
      end
    end
    in_tvalid <= 1'b0;

    while (verdicts_pending != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/ifd_pkg.sv
hdl/ifd_ram.sv
hdl/ifd_neigh_cell.sv
hdl/ipv4_forwarding_decision_unit.sv
hdl/ifd_checker.sv
bench/ipv4_forwarding_decision_checker.sv
bench/ipv4_forwarding_decision_unit_test.sv
